// ----- rtl/psp_pkg.sv -----
// Package for the pedal sensor plausibility block: payload types and constants.
package psp_pkg;

  localparam int unsigned MEDIAN_TAPS_DEF  = 5;
  localparam int unsigned AVERAGE_TAPS_DEF = 8;
  localparam int unsigned RANGE_MARGIN_DEF = 100;
  localparam int unsigned RELEASE_PCT_DEF  = 5;
  localparam int unsigned ADC_BITS_DEF     = 12;

  localparam int unsigned SampleW = ADC_BITS_DEF;
  localparam int unsigned PctW    = 7;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] REG_ADC_MIN_A     = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_ADC_MAX_A     = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_ADC_MIN_B     = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_ADC_MAX_B     = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_DEADZONE      = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_MISMATCH_LIM  = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_MISMATCH_TOUT = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_RANGE_TOUT    = 3'd7;

  localparam logic [1:0] FAULT_MISMATCH = 2'b01;
  localparam logic [1:0] FAULT_RANGE    = 2'b10;

  typedef struct packed {
    logic [SampleW-1:0] raw_a;
    logic [SampleW-1:0] raw_b;
    logic [31:0]        now_ms;
  } psp_in_t;

  typedef struct packed {
    logic [PctW-1:0] mean_pct;
    logic [PctW-1:0] percent_a;
    logic [PctW-1:0] percent_b;
    logic [1:0]      fault_code;
    logic            drive_enable;
  } psp_out_t;

endpackage

// ----- rtl/psp_med_cell.sv -----
// One cell of the median window chain: holds one sample and a rank counter.
module psp_med_cell
  import psp_pkg::*;
#(
  parameter int unsigned CntW = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               occupied,   // this cell takes part in the median
  input  logic               clr_rank,   // start a new rank count
  input  logic               cmp_en,     // compare against the broadcast sample
  input  logic [SampleW-1:0] cmp_val,    // sample of the probe cell
  input  logic               cmp_before, // probe position lies before this cell
  input  logic               wr_en,
  input  logic [SampleW-1:0] wr_val,
  output logic [SampleW-1:0] val,
  output logic [CntW-1:0]    rank        // number of samples ordered below this one
);

  logic [SampleW-1:0] val_r;
  logic [CntW-1:0]    rank_r, rank_nxt;
  logic               below;

  // Ties are broken by position, giving a stable order like insertion sort.
  assign below = (cmp_val < val_r) || ((cmp_val == val_r) && cmp_before);

  always_comb begin
    rank_nxt = rank_r;
    if (clr_rank) begin
      rank_nxt = '0;
    end else if (cmp_en && occupied && below) begin
      rank_nxt = rank_r + CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r  <= '0;
      rank_r <= '0;
    end else begin
      rank_r <= rank_nxt;
      if (wr_en) begin
        val_r <= wr_val;
      end
    end
  end

  assign val  = val_r;
  assign rank = rank_r;

endmodule

// ----- rtl/psp_sensor.sv -----
// One sensor lane: median cell chain, moving average and percent normalization.
module psp_sensor
  import psp_pkg::*;
#(
  parameter int unsigned MEDIAN_TAPS  = MEDIAN_TAPS_DEF,
  parameter int unsigned AVERAGE_TAPS = AVERAGE_TAPS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [SampleW-1:0] sample,
  input  logic [SampleW-1:0] cal_lo,
  input  logic [SampleW-1:0] cal_hi,
  input  logic [PctW-1:0]    deadzone,
  output logic               done,
  output logic [PctW-1:0]    pct
);

  localparam int unsigned MIdxW = (MEDIAN_TAPS > 1) ? $clog2(MEDIAN_TAPS) : 1;
  localparam int unsigned MCntW = $clog2(MEDIAN_TAPS + 1);
  localparam int unsigned AIdxW = (AVERAGE_TAPS > 1) ? $clog2(AVERAGE_TAPS) : 1;
  localparam int unsigned ACntW = $clog2(AVERAGE_TAPS + 1);
  localparam int unsigned SumW  = SampleW + ACntW;
  localparam int unsigned NumW  = SampleW + 7;

  typedef enum logic [3:0] {
    S_IDLE, S_WRITE, S_PROBE, S_PICK, S_ASUM, S_ADIV, S_PCTSET, S_PCTDIV,
    S_DZSET, S_DZDIV, S_DONE
  } state_t;

  state_t state_r;

  logic [MIdxW-1:0]   mslot_r;
  logic [MCntW-1:0]   mfill_r;
  logic [MIdxW-1:0]   probe_r;
  logic [SampleW-1:0] median_r;
  logic [SampleW-1:0] avg_win_r [AVERAGE_TAPS];
  logic [AIdxW-1:0]   aslot_r;
  logic [ACntW-1:0]   afill_r;
  logic [AIdxW-1:0]   aidx_r;
  logic [SumW-1:0]    sum_r;
  // Shared restoring divider, one quotient bit per cycle.
  logic [NumW-1:0]    num_r;
  logic [NumW-1:0]    den_r;
  logic [NumW-1:0]    rem_r;
  logic [NumW-1:0]    quo_r;
  logic [4:0]         bit_r;
  logic [PctW-1:0]    pct_r;
  logic [NumW-1:0]    rem_shift;

  logic [SampleW-1:0] cell_val  [MEDIAN_TAPS];
  logic [MCntW-1:0]   cell_rank [MEDIAN_TAPS];
  logic               clr_rank, cmp_en;
  logic [MCntW-1:0]   want_rank;

  assign clr_rank  = (state_r == S_WRITE);
  assign cmp_en    = (state_r == S_PROBE);
  assign want_rank = mfill_r >> 1;

  for (genvar g = 0; g < MEDIAN_TAPS; g++) begin : g_cell
    psp_med_cell #(.CntW(MCntW)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .occupied  (MCntW'(g) < mfill_r),
      .clr_rank  (clr_rank),
      .cmp_en    (cmp_en),
      .cmp_val   (cell_val[probe_r]),
      .cmp_before(probe_r < MIdxW'(g)),
      .wr_en     (state_r == S_IDLE && start && mslot_r == MIdxW'(g)),
      .wr_val    (sample),
      .val       (cell_val[g]),
      .rank      (cell_rank[g])
    );
  end

  assign rem_shift = {rem_r[NumW-2:0], num_r[bit_r]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      mslot_r <= '0;
      mfill_r <= '0;
      aslot_r <= '0;
      afill_r <= '0;
      probe_r <= '0;
      for (int i = 0; i < AVERAGE_TAPS; i++) begin
        avg_win_r[i] <= '0;
      end
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            mslot_r <= (mslot_r == MIdxW'(MEDIAN_TAPS - 1)) ? '0 : mslot_r + MIdxW'(1);
            if (mfill_r < MCntW'(MEDIAN_TAPS)) begin
              mfill_r <= mfill_r + MCntW'(1);
            end
            state_r <= S_WRITE;
          end
        end
        S_WRITE: begin
          probe_r <= '0;
          state_r <= S_PROBE;
        end
        S_PROBE: begin
          // Each occupied probe adds to the rank of every cell it sorts below.
          if (MCntW'(probe_r) + MCntW'(1) >= mfill_r) begin
            state_r <= S_PICK;
          end else begin
            probe_r <= probe_r + MIdxW'(1);
          end
        end
        S_PICK: begin
          for (int i = 0; i < MEDIAN_TAPS; i++) begin
            if (MCntW'(i) < mfill_r && cell_rank[i] == want_rank) begin
              median_r <= cell_val[i];
            end
          end
          state_r <= S_ASUM;
          aidx_r  <= '0;
          sum_r   <= '0;
        end
        S_ASUM: begin
          // First cycle stores the new median, then sums one entry a cycle.
          if (aidx_r == '0 && sum_r == '0) begin
            avg_win_r[aslot_r] <= median_r;
            aslot_r <= (aslot_r == AIdxW'(AVERAGE_TAPS - 1)) ? '0 : aslot_r + AIdxW'(1);
            if (afill_r < ACntW'(AVERAGE_TAPS)) begin
              afill_r <= afill_r + ACntW'(1);
            end
            sum_r <= {SumW{1'b1}};
          end else begin
            if (sum_r == {SumW{1'b1}}) begin
              sum_r <= SumW'(avg_win_r[aidx_r]);
            end else begin
              sum_r <= sum_r + SumW'(avg_win_r[aidx_r]);
            end
            if (ACntW'(aidx_r) + ACntW'(1) >= afill_r) begin
              state_r <= S_ADIV;
              num_r   <= NumW'((sum_r == {SumW{1'b1}}) ? SumW'(avg_win_r[aidx_r])
                                 : sum_r + SumW'(avg_win_r[aidx_r]));
              den_r   <= NumW'(afill_r);
              rem_r   <= '0;
              quo_r   <= '0;
              bit_r   <= 5'(NumW - 1);
            end else begin
              aidx_r <= aidx_r + AIdxW'(1);
            end
          end
        end
        S_ADIV, S_PCTDIV, S_DZDIV: begin
          if (rem_shift >= den_r) begin
            rem_r <= rem_shift - den_r;
            quo_r[bit_r] <= 1'b1;
          end else begin
            rem_r <= rem_shift;
          end
          if (bit_r == '0) begin
            unique case (state_r)
              S_ADIV:   state_r <= S_PCTSET;
              S_PCTDIV: state_r <= S_DZSET;
              default:  state_r <= S_DONE;
            endcase
          end else begin
            bit_r <= bit_r - 5'd1;
          end
        end
        S_PCTSET: begin
          // quo_r holds the averaged filter value.
          rem_r <= '0;
          bit_r <= 5'(NumW - 1);
          if (quo_r[SampleW-1:0] <= cal_lo) begin
            pct_r <= '0;
            state_r <= S_DONE;
          end else if (quo_r[SampleW-1:0] >= cal_hi) begin
            pct_r <= PctW'(100);
            state_r <= S_DONE;
          end else begin
            num_r <= NumW'(quo_r[SampleW-1:0] - cal_lo) * NumW'(100);
            den_r <= NumW'(cal_hi - cal_lo);
            quo_r <= '0;
            state_r <= S_PCTDIV;
          end
        end
        S_DZSET: begin
          rem_r <= '0;
          bit_r <= 5'(NumW - 1);
          if (quo_r <= NumW'(deadzone)) begin
            pct_r <= '0;
            state_r <= S_DONE;
          end else begin
            num_r <= (quo_r - NumW'(deadzone)) * NumW'(100);
            den_r <= NumW'(100) - NumW'(deadzone);
            quo_r <= '0;
            state_r <= S_DZDIV;
          end
        end
        S_DONE: begin
          if (quo_r > NumW'(100) && pct_r == '1) begin
            pct_r <= PctW'(100);
          end
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
      // The rescale quotient lands after its divide; clamp it there.
      if (state_r == S_DZDIV && bit_r == '0) begin
        pct_r <= '1;
      end
    end
  end

  logic [NumW-1:0] dz_final;
  assign dz_final = quo_r;

  always_comb begin
    pct = pct_r;
    if (pct_r == '1) begin
      pct = (dz_final > NumW'(100)) ? PctW'(100) : dz_final[PctW-1:0];
    end
  end

  assign done = (state_r == S_DONE);

endmodule

// ----- rtl/pedal_sensor_plausibility.sv -----
// Top level of the dual pedal sensor filter with plausibility supervision.
//
// Input items arrive on the in_ channel (valid/stall) and carry two raw ADC
// samples and a millisecond tick. Each accepted transfer produces exactly one
// result transfer on the out_ channel: both sensor percents, their truncated
// mean, the latched fault code and the torque enable.
// Each sensor lane runs its median through a row of compare cells that rank
// the held samples, one probe per cycle, then sums the average window one
// entry a cycle and uses a shared bit-serial divider three times.
// With filled windows and a value between the calibration limits and above
// the deadzone, all three divides run before the result is registered and
// make up most of the work. A clamped value skips later divides.
// One item is in work at a time; in_stall is high while it is, so the next
// transfer can be taken while the result of the last one is offered.
// The result sits in an output register; while the receiver stalls it holds,
// the next item is taken and worked, and its result waits in the lanes with
// in_stall high until the output register is free.
// Synchronous reset clears windows, counters, debounce timers, latched faults
// and loads the default calibration. Configuration writes on the cfg_ port
// are always ready and should only occur while the block is idle.
module pedal_sensor_plausibility
  import psp_pkg::*;
#(
  parameter int unsigned MEDIAN_TAPS  = MEDIAN_TAPS_DEF,
  parameter int unsigned AVERAGE_TAPS = AVERAGE_TAPS_DEF,
  parameter int unsigned RANGE_MARGIN = RANGE_MARGIN_DEF,
  parameter int unsigned RELEASE_PCT  = RELEASE_PCT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  psp_in_t            in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output psp_out_t           out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [15:0]        cfg_data
);

  logic [SampleW-1:0] min_a_r, max_a_r, min_b_r, max_b_r;
  logic [PctW-1:0]    dz_r, mlim_r;
  logic [15:0]        mtout_r, rtout_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_a_r <= 12'd400;  max_a_r <= 12'd3200;
      min_b_r <= 12'd400;  max_b_r <= 12'd3200;
      dz_r    <= 7'd5;     mlim_r  <= 7'd10;
      mtout_r <= 16'd100;  rtout_r <= 16'd100;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ADC_MIN_A:     min_a_r <= cfg_data[SampleW-1:0];
        REG_ADC_MAX_A:     max_a_r <= cfg_data[SampleW-1:0];
        REG_ADC_MIN_B:     min_b_r <= cfg_data[SampleW-1:0];
        REG_ADC_MAX_B:     max_b_r <= cfg_data[SampleW-1:0];
        REG_DEADZONE:      dz_r    <= cfg_data[PctW-1:0];
        REG_MISMATCH_LIM:  mlim_r  <= cfg_data[PctW-1:0];
        REG_MISMATCH_TOUT: mtout_r <= cfg_data;
        REG_RANGE_TOUT:    rtout_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencing: one item in work, result register decoupled from the input.
  logic    busy_r, start, done_a, done_b, da_r, db_r;
  psp_in_t item_r;
  logic [PctW-1:0] pa, pb;

  assign in_stall = busy_r;
  assign start    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (start) item_r <= in_data;
  end

  psp_sensor #(.MEDIAN_TAPS(MEDIAN_TAPS), .AVERAGE_TAPS(AVERAGE_TAPS)) u_lane_a (
    .clk(clk), .rst_n(rst_n), .start(start), .sample(in_data.raw_a),
    .cal_lo(min_a_r), .cal_hi(max_a_r), .deadzone(dz_r), .done(done_a), .pct(pa)
  );
  psp_sensor #(.MEDIAN_TAPS(MEDIAN_TAPS), .AVERAGE_TAPS(AVERAGE_TAPS)) u_lane_b (
    .clk(clk), .rst_n(rst_n), .start(start), .sample(in_data.raw_b),
    .cal_lo(min_b_r), .cal_hi(max_b_r), .deadzone(dz_r), .done(done_b), .pct(pb)
  );

  logic [PctW-1:0] pa_r, pb_r;
  logic both_done;
  assign both_done = (da_r || done_a) && (db_r || done_b);

  // Debounce and fault latch.
  logic        mrun_r, rrun_a_r, rrun_b_r, latched_r;
  logic [31:0] msince_r, rsince_a_r, rsince_b_r;
  logic [1:0]  bits_r;
  logic [PctW-1:0] fa, fb, diff;
  logic        mcond, rcond_a, rcond_b, merr, rerr_a, rerr_b;
  logic [1:0]  newbits;
  logic [SampleW:0] low_a, low_b, high_a, high_b;

  assign fa   = done_a ? pa : pa_r;
  assign fb   = done_b ? pb : pb_r;
  assign diff = (fa > fb) ? fa - fb : fb - fa;
  assign mcond = diff > mlim_r;

  assign low_a  = ({1'b0, min_a_r} > (SampleW+1)'(RANGE_MARGIN))
                  ? {1'b0, min_a_r} - (SampleW+1)'(RANGE_MARGIN) : '0;
  assign low_b  = ({1'b0, min_b_r} > (SampleW+1)'(RANGE_MARGIN))
                  ? {1'b0, min_b_r} - (SampleW+1)'(RANGE_MARGIN) : '0;
  assign high_a = {1'b0, max_a_r} + (SampleW+1)'(RANGE_MARGIN);
  assign high_b = {1'b0, max_b_r} + (SampleW+1)'(RANGE_MARGIN);
  assign rcond_a = ({1'b0, item_r.raw_a} < low_a) || ({1'b0, item_r.raw_a} > high_a);
  assign rcond_b = ({1'b0, item_r.raw_b} < low_b) || ({1'b0, item_r.raw_b} > high_b);

  assign merr   = mcond && mrun_r && ((item_r.now_ms - msince_r) > 32'(mtout_r));
  assign rerr_a = rcond_a && rrun_a_r && ((item_r.now_ms - rsince_a_r) > 32'(rtout_r));
  assign rerr_b = rcond_b && rrun_b_r && ((item_r.now_ms - rsince_b_r) > 32'(rtout_r));
  assign newbits = (merr ? FAULT_MISMATCH : 2'b00) | ((rerr_a || rerr_b) ? FAULT_RANGE : 2'b00);

  logic       fin;
  logic       lat_nxt;
  logic [1:0] bits_nxt;
  assign fin = busy_r && both_done && !(out_valid && out_stall);

  always_comb begin
    lat_nxt  = latched_r;
    bits_nxt = bits_r;
    if (newbits != 2'b00) begin
      lat_nxt  = 1'b1;
      bits_nxt = newbits;
    end else if (latched_r && fa <= PctW'(RELEASE_PCT) && fb <= PctW'(RELEASE_PCT)) begin
      lat_nxt  = 1'b0;
      bits_nxt = 2'b00;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; da_r <= 1'b0; db_r <= 1'b0; out_valid <= 1'b0;
      mrun_r <= 1'b0; rrun_a_r <= 1'b0; rrun_b_r <= 1'b0;
      msince_r <= '0; rsince_a_r <= '0; rsince_b_r <= '0;
      latched_r <= 1'b0; bits_r <= '0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (start) busy_r <= 1'b1;
      if (done_a) begin da_r <= 1'b1; pa_r <= pa; end
      if (done_b) begin db_r <= 1'b1; pb_r <= pb; end
      if (fin) begin
        busy_r <= 1'b0; da_r <= 1'b0; db_r <= 1'b0;
        out_valid <= 1'b1;
        mrun_r   <= mcond;
        if (mcond && !mrun_r) msince_r <= item_r.now_ms;
        rrun_a_r <= rcond_a;
        if (rcond_a && !rrun_a_r) rsince_a_r <= item_r.now_ms;
        rrun_b_r <= rcond_b;
        if (rcond_b && !rrun_b_r) rsince_b_r <= item_r.now_ms;
        latched_r <= lat_nxt;
        bits_r    <= bits_nxt;
        out_data.mean_pct     <= PctW'(({1'b0, fa} + {1'b0, fb}) >> 1);
        out_data.percent_a    <= fa;
        out_data.percent_b    <= fb;
        out_data.fault_code   <= bits_nxt;
        out_data.drive_enable <= !lat_nxt;
      end
    end
  end

  a_torque: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.drive_enable == (out_data.fault_code == 2'b00)))
    else $error("torque enable disagrees with fault code");
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy_r)
    else $error("accepted item not in work");
  a_pct: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.percent_a <= 7'd100 && out_data.percent_b <= 7'd100))
    else $error("percent out of range");

endmodule

// ----- test/pedal_sensor_plausibility_test.sv -----
// Self-checking testbench for the pedal sensor plausibility block.
`timescale 1ns / 100ps

module pedal_sensor_plausibility_test;
  import psp_pkg::*;

  localparam int MED_TAPS = 5;
  localparam int AVG_TAPS = 8;
  localparam int MARGIN = 100;
  localparam int RELEASE = 5;
  localparam int SETTLE_CYCLES = 400;
  localparam longint CYCLE_LIMIT = 3000000;

  // Idle profiles for the sender and the receiver.
  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  psp_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  psp_out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  always #1 clk = ~clk;

  pedal_sensor_plausibility dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Calibration mirror, kept in step with every register write.
  int unsigned cal_min[2], cal_max[2];
  int unsigned dz_pct, mm_limit, mm_tout, rng_tout;

  // Filter and debounce state of the predictor.
  int unsigned med_win[2][MED_TAPS];
  int unsigned med_slot[2], med_fill[2];
  int unsigned avg_win[2][AVG_TAPS];
  int unsigned avg_slot[2], avg_fill[2];
  bit mm_run, rng_run[2];
  logic [31:0] mm_since, rng_since[2];
  bit latched;
  logic [1:0] fault_now;

  psp_out_t pending_results[$];

  idle_mode_t idle_mode = IDLE_NONE;
  bit hold_receiver = 1'b0;
  int unsigned items_sent = 0, results_seen = 0, mismatches = 0, faults_seen = 0;
  longint cycles = 0;
  logic [31:0] clock_ms = 0;

  function automatic bit chance(int unsigned pct);
    return ($urandom_range(99) < pct);
  endfunction

  function automatic int unsigned filter_sample(int s, int unsigned v);
    int unsigned tmp[MED_TAPS];
    int unsigned key, med, sum;
    int n, j;
    med_win[s][med_slot[s]] = v;
    med_slot[s] = (med_slot[s] + 1) % MED_TAPS;
    if (med_fill[s] < MED_TAPS) med_fill[s]++;
    n = med_fill[s];
    for (int i = 0; i < n; i++) tmp[i] = med_win[s][i];
    for (int i = 1; i < n; i++) begin
      key = tmp[i];
      j = i;
      while (j > 0 && tmp[j-1] > key) begin
        tmp[j] = tmp[j-1];
        j--;
      end
      tmp[j] = key;
    end
    med = tmp[n/2];
    avg_win[s][avg_slot[s]] = med;
    avg_slot[s] = (avg_slot[s] + 1) % AVG_TAPS;
    if (avg_fill[s] < AVG_TAPS) avg_fill[s]++;
    sum = 0;
    for (int i = 0; i < avg_fill[s]; i++) sum += avg_win[s][i];
    return sum / avg_fill[s];
  endfunction

  function automatic int unsigned scale_percent(int unsigned f, int unsigned lo,
                                                int unsigned hi);
    int unsigned pct, r;
    if (f <= lo) return 0;
    if (f >= hi) return 100;
    pct = ((f - lo) * 100) / (hi - lo);
    if (pct <= dz_pct) return 0;
    r = ((pct - dz_pct) * 100) / (100 - dz_pct);
    return (r > 100) ? 100 : r;
  endfunction

  // Timed debounce: the first step only arms the timer.
  function automatic bit debounce_step(bit cond, ref bit running, ref logic [31:0] since,
                                       input logic [31:0] now, input int unsigned tout);
    logic [31:0] elapsed;
    if (!cond) begin
      running = 1'b0;
      return 1'b0;
    end
    if (!running) begin
      running = 1'b1;
      since = now;
      return 1'b0;
    end
    elapsed = now - since;
    return elapsed > tout;
  endfunction

  function automatic psp_out_t predict_pedal(psp_in_t item);
    int unsigned raw[2], pct[2], diff, low, high;
    logic [1:0] new_bits;
    psp_out_t res;
    raw[0] = 32'(item.raw_a);
    raw[1] = 32'(item.raw_b);
    new_bits = '0;
    for (int s = 0; s < 2; s++)
      pct[s] = scale_percent(filter_sample(s, raw[s]), cal_min[s], cal_max[s]);
    diff = (pct[0] > pct[1]) ? pct[0] - pct[1] : pct[1] - pct[0];
    if (debounce_step(diff > mm_limit, mm_run, mm_since, item.now_ms, mm_tout))
      new_bits |= FAULT_MISMATCH;
    for (int s = 0; s < 2; s++) begin
      low = (cal_min[s] > MARGIN) ? cal_min[s] - MARGIN : 0;
      high = cal_max[s] + MARGIN;
      if (debounce_step(raw[s] < low || raw[s] > high, rng_run[s], rng_since[s],
                        item.now_ms, rng_tout))
        new_bits |= FAULT_RANGE;
    end
    if (new_bits != 0) begin
      latched = 1'b1;
      fault_now = new_bits;
    end
    if (latched && new_bits == 0 && pct[0] <= RELEASE && pct[1] <= RELEASE) begin
      latched = 1'b0;
      fault_now = '0;
    end
    res.mean_pct = 7'((pct[0] + pct[1]) / 2);
    res.percent_a = 7'(pct[0]);
    res.percent_b = 7'(pct[1]);
    res.fault_code = fault_now;
    res.drive_enable = !latched;
    return res;
  endfunction

  task automatic reset_predictor();
    cal_min = '{400, 400};
    cal_max = '{3200, 3200};
    dz_pct = 5; mm_limit = 10; mm_tout = 100; rng_tout = 100;
    for (int s = 0; s < 2; s++) begin
      med_slot[s] = 0; med_fill[s] = 0; avg_slot[s] = 0; avg_fill[s] = 0;
      rng_run[s] = 0; rng_since[s] = 0;
      foreach (med_win[s][i]) med_win[s][i] = 0;
      foreach (avg_win[s][i]) avg_win[s][i] = 0;
    end
    mm_run = 0; mm_since = 0; latched = 0; fault_now = '0;
  endtask

  // One register write through the configuration channel, mirrored locally.
  task automatic write_register(logic [CfgIdxW-1:0] idx, int unsigned value);
    cfg_index <= idx;
    cfg_data <= value[15:0];
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_ADC_MIN_A: cal_min[0] = value & 12'hFFF;
      REG_ADC_MAX_A: cal_max[0] = value & 12'hFFF;
      REG_ADC_MIN_B: cal_min[1] = value & 12'hFFF;
      REG_ADC_MAX_B: cal_max[1] = value & 12'hFFF;
      REG_DEADZONE: dz_pct = value & 7'h7F;
      REG_MISMATCH_LIM: mm_limit = value & 7'h7F;
      REG_MISMATCH_TOUT: mm_tout = value & 16'hFFFF;
      REG_RANGE_TOUT: rng_tout = value & 16'hFFFF;
      default: ;
    endcase
  endtask

  task automatic write_calibration(int unsigned min_a, int unsigned max_a,
                                   int unsigned min_b, int unsigned max_b,
                                   int unsigned dz, int unsigned lim,
                                   int unsigned mto, int unsigned rto);
    write_register(REG_ADC_MIN_A, min_a);
    write_register(REG_ADC_MAX_A, max_a);
    write_register(REG_ADC_MIN_B, min_b);
    write_register(REG_ADC_MAX_B, max_b);
    write_register(REG_DEADZONE, dz);
    write_register(REG_MISMATCH_LIM, lim);
    write_register(REG_MISMATCH_TOUT, mto);
    write_register(REG_RANGE_TOUT, rto);
  endtask

  // Sends one item; the expectation is queued when the transfer happens.
  // Valid stays high into the next item unless the sender idles first.
  task automatic send_sample(int unsigned raw_a, int unsigned raw_b, logic [31:0] now);
    psp_in_t item;
    if (idle_mode == IDLE_SENDER || idle_mode == IDLE_BOTH) begin
      while (chance(idle_mode == IDLE_BOTH ? 6 : 46)) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    item.raw_a = raw_a[11:0];
    item.raw_b = raw_b[11:0];
    item.now_ms = now;
    in_data <= item;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(predict_pedal(item));
    items_sent++;
  endtask

  // Waits until every result is in, then lets the block go quiet.
  task automatic drain_block();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Receiver stall pattern, driven at each rising edge.
  always @(posedge clk) begin
    if (hold_receiver)
      out_stall <= 1'b1;
    else if (idle_mode == IDLE_RECEIVER)
      out_stall <= chance(46);
    else if (idle_mode == IDLE_BOTH)
      out_stall <= chance(6);
    else
      out_stall <= 1'b0;
  end

  // Result checker: each transfer is compared with the oldest prediction.
  always @(posedge clk) begin
    psp_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected result %p", out_data);
      end else begin
        want = pending_results.pop_front();
        if (!out_data.drive_enable) faults_seen++;
        if (out_data !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: result %0d expected %p got %p", results_seen, want, out_data);
        end
      end
    end
  end

  // Cycle limit guards against a hung handshake.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("pedal_sensor_plausibility verification failed");
      $finish;
    end
  end

  // Extremes of both sample fields and of the time tick at default calibration.
  task automatic test_extremes();
    send_sample(0, 0, 32'd0);
    send_sample(4095, 4095, 32'hFFFF_FFFF);
    send_sample(4095, 0, 32'd5);
    send_sample(12'hAAA, 12'h555, 32'hAAAA_AAAA);
    send_sample(12'h555, 12'hAAA, 32'h5555_5555);
    for (int i = 0; i < 8; i++) send_sample(400, 400, 32'd100 + i);
    drain_block();
  endtask

  // Mismatch that persists past its timeout latches, then releases at rest.
  task automatic test_mismatch_latch();
    write_register(REG_MISMATCH_TOUT, 20);
    for (int i = 0; i < 12; i++) send_sample(3000, 1000, 32'd1000 + 10 * i);
    for (int i = 0; i < 12; i++) send_sample(400, 400, 32'd2000 + i);
    drain_block();
  endtask

  // Out-of-range raw value with the timer wrapping across 2^32.
  task automatic test_range_wrap();
    write_register(REG_RANGE_TOUT, 0);
    for (int i = 0; i < 6; i++) send_sample(4000, 4000, 32'hFFFF_FFFE + i);
    for (int i = 0; i < 10; i++) send_sample(0, 0, 32'd50 + i);
    drain_block();
  endtask

  // Degenerate calibration (min >= max), deadzone of 99 and extreme registers.
  task automatic test_calibration_edges();
    write_calibration(2000, 2000, 4095, 0, 99, 0, 65535, 65535);
    for (int i = 0; i < 6; i++) send_sample(2500 * (i & 1), 4095 - 819 * i, 32'd3000 + i);
    drain_block();
    write_calibration(0, 4095, 50, 4095, 0, 100, 0, 0);
    for (int i = 0; i < 6; i++) send_sample(700 * i, 4095 - 700 * i, 32'd4000 + i);
    drain_block();
  endtask

  // Random items, mostly plausible pedal travel with noise and faults mixed in.
  task automatic run_random(int count, idle_mode_t mode);
    int unsigned pos, ra, rb;
    idle_mode = mode;
    for (int i = 0; i < count; i++) begin
      clock_ms += $urandom_range(3);
      if (chance(8)) clock_ms += $urandom_range(300);
      pos = $urandom_range(4095);
      if (chance(70)) begin
        ra = pos;
        rb = pos + $urandom_range(120);
        if (rb > 4095) rb = 4095;
      end else begin
        ra = $urandom_range(4095);
        rb = $urandom_range(4095);
      end
      if (chance(15)) begin
        ra = $urandom_range(250);
        rb = $urandom_range(250);
      end
      send_sample(ra, rb, clock_ms);
    end
    drain_block();
    idle_mode = IDLE_NONE;
  endtask

  task automatic run_random_config();
    write_calibration($urandom_range(800), 2400 + $urandom_range(1695),
                      $urandom_range(800), 2400 + $urandom_range(1695),
                      $urandom_range(99), $urandom_range(100),
                      $urandom_range(200), $urandom_range(200));
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering items.
  task automatic test_back_pressure();
    int unsigned hold_cycles;
    hold_cycles = 0;
    hold_receiver = 1'b1;
    fork
      for (int i = 0; i < 6; i++) send_sample(1200 + 100 * i, 1200 + 100 * i, 32'd9000 + i);
      begin
        while (hold_cycles < 600) begin
          @(posedge clk);
          hold_cycles++;
        end
        hold_receiver = 1'b0;
      end
    join
    drain_block();
  endtask

  initial begin
    reset_predictor();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_mismatch_latch();
    test_range_wrap();
    test_calibration_edges();
    write_calibration(400, 3200, 400, 3200, 5, 10, 100, 100);
    test_back_pressure();
    run_random(300, IDLE_NONE);
    run_random_config();
    run_random(280, IDLE_SENDER);
    run_random_config();
    run_random(280, IDLE_RECEIVER);
    run_random_config();
    run_random(230, IDLE_BOTH);
    $display("Covered %0d items and %0d results, %0d with torque blocked,",
             items_sent, results_seen, faults_seen);
    $display("over directed edge cases and four idle profiles with varied calibration.");
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("pedal_sensor_plausibility verification clean");
    end else begin
      $display("%0d mismatches, %0d results outstanding", mismatches, pending_results.size());
      $display("pedal_sensor_plausibility verification failed");
    end
    $finish;
  end

endmodule
